// ===== rtl/wbps_pkg.sv =====
// shared types and constants of the wildcard byte pattern scanner
package wbps_pkg;

	localparam int DATA_W          = 8;
	localparam int OFFSET_W        = 32;
	localparam int SEG_W           = 8;
	localparam int PAT_BYTES_MAX   = 16;
	localparam int MAX_PATTERN_DEF = 16;
	localparam int LEN_CFG_W       = 5;
	localparam int MASK_W          = 16;
	localparam int APB_DATA_W      = 64;
	localparam int APB_ADDR_W      = 6;
	localparam int REG_IDX_W       = 3;

	localparam logic [OFFSET_W-1:0] OFFSET_MAX  = '1;
	localparam logic [SEG_W-1:0]    SEGMENT_MAX = '1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PAT_LO     = 3'd0,
		REG_PAT_HI     = 3'd1,
		REG_WILDCARD   = 3'd2,
		REG_LENGTH     = 3'd3,
		REG_FIRST_ONLY = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [APB_DATA_W-1:0] pattern_high;
		logic [APB_DATA_W-1:0] pattern_low;
		logic [MASK_W-1:0]     wildcard_mask;
		logic [LEN_CFG_W-1:0]  pattern_length;
		logic                  first_only;
	} cfg_t;

endpackage

// ===== rtl/wbps_in_if.sv =====
// byte stream channel into the scanner
interface wbps_in_if;
	logic                       valid;
	logic                       ready;
	logic [wbps_pkg::DATA_W-1:0] data_byte;
	logic                       segment_start;
	logic                       search_start;

	modport source (output valid, data_byte, segment_start, search_start, input ready);
	modport sink (input valid, data_byte, segment_start, search_start, output ready);
endinterface

// ===== rtl/wbps_out_if.sv =====
// match report channel out of the scanner
interface wbps_out_if;
	logic                         valid;
	logic                         ready;
	logic [wbps_pkg::OFFSET_W-1:0] match_offset;
	logic [wbps_pkg::SEG_W-1:0]    segment_number;

	modport source (output valid, match_offset, segment_number, input ready);
	modport sink (input valid, match_offset, segment_number, output ready);
endinterface

// ===== rtl/wbps_cfg_regs.sv =====
// apb register file holding pattern, wildcard mask, length and mode
module wbps_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wbps_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [wbps_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [wbps_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output wbps_pkg::cfg_t                    cfg
);
	import wbps_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	// registers sit on 8-byte boundaries
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PAT_LO:     cfg_q.pattern_low    <= pwdata;
				REG_PAT_HI:     cfg_q.pattern_high   <= pwdata;
				REG_WILDCARD:   cfg_q.wildcard_mask  <= pwdata[MASK_W-1:0];
				REG_LENGTH:     cfg_q.pattern_length <= pwdata[LEN_CFG_W-1:0];
				REG_FIRST_ONLY: cfg_q.first_only     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PAT_LO:     prdata = cfg_q.pattern_low;
			REG_PAT_HI:     prdata = cfg_q.pattern_high;
			REG_WILDCARD:   prdata = APB_DATA_W'(cfg_q.wildcard_mask);
			REG_LENGTH:     prdata = APB_DATA_W'(cfg_q.pattern_length);
			REG_FIRST_ONLY: prdata = APB_DATA_W'(cfg_q.first_only);
			default:        prdata = '0;
		endcase
	end
endmodule

// ===== rtl/wbps_match.sv =====
// parallel compare of the byte window against the wildcard pattern
module wbps_match #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
	input  logic [MAX_PATTERN-1:0][wbps_pkg::DATA_W-1:0] window,
	input  wbps_pkg::cfg_t                               cfg,
	input  logic [wbps_pkg::OFFSET_W-1:0]                cur,
	output logic                                         hit,
	output logic [wbps_pkg::OFFSET_W-1:0]                start_offset
);
	import wbps_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [PAT_BYTES_MAX-1:0][DATA_W-1:0] pat;
	logic [LEN_W-1:0]                     len;
	logic [LEN_W-1:0]                     len_m1;
	logic [LEN_W-1:0]                     pos;
	logic                                 all_ok;

	assign pat = {cfg.pattern_high, cfg.pattern_low};

	// lengths above the window depth clamp to the full window
	always_comb begin
		if (cfg.pattern_length > LEN_CFG_W'(MAX_PATTERN))
			len = LEN_W'(MAX_PATTERN);
		else
			len = cfg.pattern_length[LEN_W-1:0];
	end

	assign len_m1 = len - LEN_W'(1);

	// pattern byte i lines up with window entry len-1-i, newest byte at entry 0
	always_comb begin
		all_ok = 1'b1;
		pos    = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			pos = len_m1 - LEN_W'(i);
			if (!(LEN_W'(i) >= len || cfg.wildcard_mask[i] ||
			      window[pos[IDX_W-1:0]] == pat[i]))
				all_ok = 1'b0;
		end
	end

	assign hit          = (len != '0) && (cur >= OFFSET_W'(len_m1)) && all_ok;
	assign start_offset = cur - OFFSET_W'(len_m1);
endmodule

// ===== rtl/wildcard_byte_pattern_scan.sv =====
// Wildcard byte pattern scanner: takes one byte per clock cycle and reports
// each position where the last pattern_length bytes of the current segment
// match the configured pattern, with don't-care bytes. A byte goes into an
// input register, the window compare and offset update run while it is held
// there, and the result lands in an output register. The sustained rate is
// one byte per cycle unless the output stalls, set by the combinational
// compare of the full window; a report left waiting in the output register
// stalls the input once the input register also holds a byte.
// Configuration is through an APB port with 64-bit registers at 8-byte steps.
module wildcard_byte_pattern_scan #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	wbps_in_if.sink                         bytes,
	wbps_out_if.source                      results,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wbps_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [wbps_pkg::APB_DATA_W-1:0] pwdata,
	output logic [wbps_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import wbps_pkg::*;

	cfg_t cfg;

	logic              valid_s1;
	logic [DATA_W-1:0] data_s1;
	logic              seg_start_s1;
	logic              srch_start_s1;

	logic [MAX_PATTERN-1:0][DATA_W-1:0] window_q;
	logic [MAX_PATTERN-1:0][DATA_W-1:0] window_nxt;
	logic [OFFSET_W-1:0]                seg_offset_q;
	logic [SEG_W-1:0]                   seg_index_q;
	logic                               seen_q;

	logic [OFFSET_W-1:0] cur;
	logic [SEG_W-1:0]    seg_index_nxt;
	logic                seen_eff;
	logic                hit;
	logic [OFFSET_W-1:0] start_offset;
	logic                report;
	logic                advance;

	logic                out_valid_q;
	logic [OFFSET_W-1:0] match_offset_q;
	logic [SEG_W-1:0]    segment_number_q;

	wbps_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage 1 moves on when the output register is empty or being drained
	assign advance     = valid_s1 && (!out_valid_q || results.ready);
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (bytes.ready)
				valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			data_s1       <= bytes.data_byte;
			seg_start_s1  <= bytes.segment_start;
			srch_start_s1 <= bytes.search_start;
		end
	end

	// position of this byte; a search start also opens segment zero
	always_comb begin
		if (srch_start_s1) begin
			cur           = '0;
			seg_index_nxt = '0;
			seen_eff      = 1'b0;
		end else if (seg_start_s1) begin
			cur           = '0;
			seg_index_nxt = (seg_index_q == SEGMENT_MAX) ? seg_index_q
			                                             : seg_index_q + SEG_W'(1);
			seen_eff      = seen_q;
		end else begin
			cur           = seg_offset_q;
			seg_index_nxt = seg_index_q;
			seen_eff      = seen_q;
		end
	end

	always_comb begin
		window_nxt[0] = data_s1;
		for (int j = 1; j < MAX_PATTERN; j++)
			window_nxt[j] = window_q[j-1];
	end

	wbps_match #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_match (
		.window       (window_nxt),
		.cfg          (cfg),
		.cur          (cur),
		.hit          (hit),
		.start_offset (start_offset)
	);

	assign report = hit && !(cfg.first_only && seen_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= '0;
			seg_offset_q <= '0;
			seg_index_q  <= '0;
			seen_q       <= 1'b0;
		end else if (advance) begin
			window_q     <= window_nxt;
			seg_offset_q <= (cur == OFFSET_MAX) ? cur : cur + OFFSET_W'(1);
			seg_index_q  <= seg_index_nxt;
			seen_q       <= seen_eff || hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= report;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && report) begin
			match_offset_q   <= start_offset;
			segment_number_q <= seg_index_nxt;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.match_offset   = match_offset_q;
	assign results.segment_number = segment_number_q;
endmodule

// ===== bench/tb_wildcard_byte_pattern_scan.sv =====
// testbench for the wildcard byte pattern scanner: directed and random scans against a local predictor
`timescale 1ns / 100ps

module tb_wildcard_byte_pattern_scan;
	import wbps_pkg::*;

	localparam int ITEM_TARGET    = 1100;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SAT_SEGMENTS   = 270;
	localparam int PRINT_LIMIT    = 30;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              seg_start;
		logic              srch_start;
	} scan_item_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [SEG_W-1:0]    segment;
	} match_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	wbps_in_if  byte_ch();
	wbps_out_if match_ch();

	wildcard_byte_pattern_scan dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch.sink),
		.results (match_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state and its copy of the registers
	cfg_t                    scan_cfg;
	logic [15:0][DATA_W-1:0] win;
	logic [OFFSET_W-1:0]     seg_off;
	logic [SEG_W-1:0]        seg_idx;
	logic                    seen;

	scan_item_t byte_queue[$];
	match_t     pending_matches[$];
	scan_item_t drv_item;
	match_t     got_match;
	match_t     want_match;

	int   errors = 0;
	int   items_queued = 0;
	int   bytes_scanned = 0;
	int   matches_checked = 0;
	int   configs_done = 0;
	int   max_seg = 0;
	int   gap_left = 0;
	int   burst_left = 0;
	int   idle_cycles = 0;
	logic byte_taken;
	logic no_gaps;
	logic ready_always;
	logic [15:0] stall_pattern;
	logic [3:0]  stall_pos;

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// advance the predictor by one byte and queue the match it reports, if any
	function automatic void scan_byte(input logic [DATA_W-1:0] data, input logic seg_st,
			input logic srch_st);
		logic [OFFSET_W-1:0] cur;
		logic [127:0]        pat;
		int                  len;
		logic                hit;
		match_t              found;
		if (srch_st) begin
			seen    = 1'b0;
			seg_idx = '0;
			seg_off = '0;
		end else if (seg_st) begin
			if (seg_idx != SEGMENT_MAX)
				seg_idx++;
			seg_off = '0;
		end
		if (seg_idx > max_seg)
			max_seg = seg_idx;
		cur = seg_off;
		win = {win[14:0], data};
		pat = {scan_cfg.pattern_high, scan_cfg.pattern_low};
		len = (scan_cfg.pattern_length > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF
			: scan_cfg.pattern_length;
		hit = 1'b0;
		if (len != 0 && cur >= OFFSET_W'(len - 1)) begin
			hit = 1'b1;
			for (int i = 0; i < len; i++)
				if (!scan_cfg.wildcard_mask[i] && win[len-1-i] != pat[8*i +: 8])
					hit = 1'b0;
		end
		if (hit) begin
			if (!(scan_cfg.first_only && seen)) begin
				found.offset    = cur - OFFSET_W'(len - 1);
				found.segment   = seg_idx;
				pending_matches = {pending_matches, found};
			end
			seen = 1'b1;
		end
		if (cur != OFFSET_MAX)
			seg_off = cur + 1'b1;
	endfunction

	// one APB transfer; a write updates the predictor's registers, a read is checked
	task automatic apb_access(input reg_idx_t idx, input logic wr, input logic [63:0] value);
		logic [63:0] want;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (wr) begin
			case (idx)
				REG_PAT_LO:     scan_cfg.pattern_low    = value;
				REG_PAT_HI:     scan_cfg.pattern_high   = value;
				REG_WILDCARD:   scan_cfg.wildcard_mask  = value[MASK_W-1:0];
				REG_LENGTH:     scan_cfg.pattern_length = value[LEN_CFG_W-1:0];
				REG_FIRST_ONLY: scan_cfg.first_only     = value[0];
				default: ;
			endcase
		end else begin
			case (idx)
				REG_PAT_LO:     want = scan_cfg.pattern_low;
				REG_PAT_HI:     want = scan_cfg.pattern_high;
				REG_WILDCARD:   want = 64'(scan_cfg.wildcard_mask);
				REG_LENGTH:     want = 64'(scan_cfg.pattern_length);
				REG_FIRST_ONLY: want = 64'(scan_cfg.first_only);
				default:        want = '0;
			endcase
			if (prdata !== want)
				report_mismatch($sformatf("register %s read %h, expected %h",
					idx.name(), prdata, want));
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
			input logic [MASK_W-1:0] mask, input logic [LEN_CFG_W-1:0] len, input logic fo);
		apb_access(REG_PAT_LO, 1'b1, lo);
		apb_access(REG_PAT_HI, 1'b1, hi);
		apb_access(REG_WILDCARD, 1'b1, 64'(mask));
		apb_access(REG_LENGTH, 1'b1, 64'(len));
		apb_access(REG_FIRST_ONLY, 1'b1, 64'(fo));
		for (int i = 0; i <= REG_FIRST_ONLY; i++)
			apb_access(reg_idx_t'(i), 1'b0, '0);
		configs_done++;
	endtask

	task automatic push_scan_byte(input logic [DATA_W-1:0] data, input logic seg_st,
			input logic srch_st);
		scan_item_t entry;
		entry.data       = data;
		entry.seg_start  = seg_st;
		entry.srch_start = srch_st;
		byte_queue       = {byte_queue, entry};
		items_queued++;
	endtask

	// mostly copies of the pattern with random wildcard bytes, some of them broken,
	// mixed with random bytes and occasional segment or search starts
	task automatic queue_scan_phase(input int n);
		logic [127:0]      pat;
		logic [DATA_W-1:0] b;
		int                len;
		int                pos;
		int                made;
		pat  = {scan_cfg.pattern_high, scan_cfg.pattern_low};
		len  = (scan_cfg.pattern_length > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF
			: scan_cfg.pattern_length;
		made = 0;
		while (made < n) begin
			if (len != 0 && $urandom_range(0, 2) != 0) begin
				pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : -1;
				for (int k = 0; k < len; k++) begin
					b = scan_cfg.wildcard_mask[k] ? DATA_W'($urandom) : pat[8*k +: 8];
					if (k == pos)
						b = b ^ DATA_W'($urandom_range(1, 255));
					push_scan_byte(b, k == 0 && $urandom_range(0, 5) == 0,
						k == 0 && $urandom_range(0, 11) == 0);
				end
				made += len;
			end else begin
				push_scan_byte(DATA_W'($urandom), $urandom_range(0, 24) == 0,
					$urandom_range(0, 39) == 0);
				made++;
			end
		end
	endtask

	task automatic wait_idle();
		while (byte_queue.size() != 0 || byte_ch.valid || pending_matches.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic pick_flow();
		no_gaps       = ($urandom_range(0, 3) == 0);
		ready_always  = ($urandom_range(0, 3) == 0);
		stall_pattern = ($urandom_range(0, 2) == 0) ? (16'($urandom) & 16'($urandom)) | 16'h1
			: 16'($urandom) | 16'h1;
	endtask

	// driver: bytes in bursts with random gaps, the receiver stalls on its own pattern
	always @(negedge clk) begin
		if (arst_n) begin
			if (!byte_ch.valid || byte_taken) begin
				if (gap_left > 0) begin
					gap_left      <= gap_left - 1;
					byte_ch.valid <= 1'b0;
				end else if (byte_queue.size() > 0) begin
					drv_item = byte_queue.pop_front();
					byte_ch.data_byte     <= drv_item.data;
					byte_ch.segment_start <= drv_item.seg_start;
					byte_ch.search_start  <= drv_item.srch_start;
					byte_ch.valid         <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left   <= no_gaps ? 0 : $urandom_range(0, 7);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
			match_ch.ready <= ready_always || stall_pattern[stall_pos];
			stall_pos      <= stall_pos + 1'b1;
		end
	end

	// monitor: predicts on each accepted byte and checks each accepted match
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_taken <= 1'b0;
		end else begin
			byte_taken <= byte_ch.valid && byte_ch.ready;
			if (match_ch.valid && match_ch.ready) begin
				got_match = '{match_ch.match_offset, match_ch.segment_number};
				if (pending_matches.size() == 0) begin
					report_mismatch($sformatf("unexpected match offset %0d segment %0d",
						got_match.offset, got_match.segment));
				end else begin
					want_match = pending_matches.pop_front();
					if (got_match.offset !== want_match.offset)
						report_mismatch($sformatf("match_offset %0d, expected %0d",
							got_match.offset, want_match.offset));
					if (got_match.segment !== want_match.segment)
						report_mismatch($sformatf("segment_number %0d, expected %0d",
							got_match.segment, want_match.segment));
					matches_checked++;
				end
			end
			if (byte_ch.valid && byte_ch.ready) begin
				scan_byte(byte_ch.data_byte, byte_ch.segment_start, byte_ch.search_start);
				bytes_scanned++;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (match_ch.valid && match_ch.ready)
				|| (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n                 = 1'b0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		byte_ch.valid          = 1'b0;
		byte_ch.data_byte      = '0;
		byte_ch.segment_start  = 1'b0;
		byte_ch.search_start   = 1'b0;
		match_ch.ready         = 1'b0;
		stall_pos              = '0;
		no_gaps                = 1'b1;
		ready_always           = 1'b1;
		stall_pattern          = 16'hFFFF;
		scan_cfg               = '0;
		win                    = '0;
		seg_off                = '0;
		seg_idx                = '0;
		seen                   = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// pattern 11 22 ?? 44
		configure(64'h0000_0000_4433_2211, 64'h0, 16'h0004, 5'd4, 1'b0);
		// bytes before any start count as segment 0
		push_scan_byte(8'h11, 1'b0, 1'b0);
		push_scan_byte(8'h22, 1'b0, 1'b0);
		push_scan_byte(8'h99, 1'b0, 1'b0);
		push_scan_byte(8'h44, 1'b0, 1'b0);
		// a match may not span a segment boundary
		push_scan_byte(8'h11, 1'b0, 1'b0);
		push_scan_byte(8'h22, 1'b0, 1'b0);
		push_scan_byte(8'h33, 1'b1, 1'b0);
		push_scan_byte(8'h44, 1'b0, 1'b0);
		// search start together with segment start
		push_scan_byte(8'h11, 1'b1, 1'b1);
		push_scan_byte(8'h22, 1'b0, 1'b0);
		push_scan_byte(8'h00, 1'b0, 1'b0);
		push_scan_byte(8'h44, 1'b0, 1'b0);
		push_scan_byte(8'h00, 1'b1, 1'b0);
		push_scan_byte(8'hFF, 1'b0, 1'b0);
		push_scan_byte(8'h11, 1'b0, 1'b0);
		push_scan_byte(8'h22, 1'b0, 1'b0);
		push_scan_byte(8'hFF, 1'b0, 1'b0);
		push_scan_byte(8'h44, 1'b0, 1'b0);
		// search start alone
		push_scan_byte(8'h11, 1'b0, 1'b1);
		push_scan_byte(8'h22, 1'b0, 1'b0);
		push_scan_byte(8'h33, 1'b0, 1'b0);
		push_scan_byte(8'h44, 1'b0, 1'b0);
		wait_idle();

		// zero length never matches, even on an all-zero window and pattern
		configure(64'h0, 64'h0, 16'h0000, 5'd0, 1'b0);
		push_scan_byte(8'h00, 1'b0, 1'b1);
		push_scan_byte(8'h00, 1'b0, 1'b0);
		push_scan_byte(8'h00, 1'b0, 1'b0);
		wait_idle();

		for (int phase = 0; items_queued < ITEM_TARGET; phase++) begin
			pick_flow();
			case (phase)
				0: configure('1, '1, 16'h0000, 5'd16, 1'b0);
				1: configure('0, '0, 16'hFFFF, 5'd31, 1'b1);
				2: configure(64'(8'($urandom)), 64'($urandom), 16'h0001, 5'd1, 1'b0);
				default: configure({$urandom, $urandom}, {$urandom, $urandom},
					($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom) & 16'($urandom),
					($urandom_range(0, 9) == 0) ? 5'd0 :
					($urandom_range(0, 8) == 0) ? 5'($urandom_range(17, 31)) :
					($urandom_range(0, 6) == 0) ? 5'($urandom_range(6, 16)) :
					5'($urandom_range(1, 5)),
					1'($urandom));
			endcase
			// every byte starts a segment, so the segment count runs into saturation
			if (phase == 2) begin
				for (int i = 0; i < SAT_SEGMENTS; i++)
					push_scan_byte(DATA_W'($urandom), 1'b1, 1'b0);
			end else begin
				queue_scan_phase($urandom_range(40, 120));
			end
			wait_idle();
		end

		$display("scanned %0d bytes under %0d register settings, checked %0d matches",
			bytes_scanned, configs_done, matches_checked);
		$display("highest segment number reached %0d, %0d mismatches", max_seg, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/wbps_pkg.sv
rtl/wbps_in_if.sv
rtl/wbps_out_if.sv
rtl/wbps_cfg_regs.sv
rtl/wbps_match.sv
rtl/wildcard_byte_pattern_scan.sv
bench/tb_wildcard_byte_pattern_scan.sv
